// ===== rtl/bts_pkg.sv =====
// ============================================================================
// bts_pkg : shared definitions for the bilinear texture sampler
// Field layout of the stream beats, register map, store geometry and the
// sequencer state encoding.
// ============================================================================
`default_nettype none

package bts_pkg;

  // Texture store geometry
  localparam int MAX_TEXELS = 65536;
  localparam int TEX_AW     = $clog2(MAX_TEXELS);
  localparam int DIM_W      = 9;        // width/height register width
  localparam int COORD_W    = 17;       // unsigned Q1.16
  localparam int FRAC_W     = 16;
  localparam int TEXEL_W    = 24;       // {red, green, blue}

  // Input beat layout (s_tdata), lowest bit first
  localparam int IDX_LSB    = 0;
  localparam int RED_LSB    = 16;
  localparam int GREEN_LSB  = 24;
  localparam int BLUE_LSB   = 32;
  localparam int U_LSB      = 40;
  localparam int V_LSB      = 57;
  localparam int S_DATA_W   = 80;
  localparam int M_DATA_W   = 24;

  // Beat kind carried in s_tuser
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Register map, decoded on paddr[2]
  localparam int  PADDR_W        = 3;
  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  localparam logic [7:0] WHITE = 8'hFF;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MULX  = 9'b000000010,
    ST_MULY  = 9'b000000100,
    ST_LOCY  = 9'b000001000,
    ST_BASE0 = 9'b000010000,
    ST_BASE1 = 9'b000100000,
    ST_READ  = 9'b001000000,
    ST_BLEND = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/bilinear_texture_sampler.sv =====
// ============================================================================
// bilinear_texture_sampler : texture store with a bilinear sampler
// One 64K x 24 single-port texel store, one shared signed multiplier and a
// small sequencer that locates, fetches and blends four neighbouring texels.
// ============================================================================
// Write beats (s_tuser = 0) store one RGB texel at texel_index; they produce
// no output beat. Sample beats (s_tuser = 1) carry u, v in unsigned Q1.16.
// The block forms x = u*width - 1 and y = v*height - 1, clamps the
// neighbouring columns and rows to the texture, reads the four texels and
// blends them with the 16-bit fractions, rounding each channel to nearest
// (ties up). Every product (u*width, v*height, two row bases and three
// products per color channel) goes through one registered multiplier, and
// the four texels come one per cycle from the single store port. With
// tex_width zero a sample answers white. s_tready is low while a sample is
// in work; write beats are taken even while a result waits on m_tready.
// Configure only while the block is idle. Reading a texel never written
// since reset returns whatever the store holds.
`default_nettype none

module bilinear_texture_sampler
  import bts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  // texel_index[15:0] red[23:16] green[31:24] blue[39:32]
  // coord_u[56:40] coord_v[73:57], zero pad [79:74]
  input  wire logic [S_DATA_W-1:0]  s_tdata,
  input  wire logic                 s_tuser,   // kind[0]
  // output stream
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [M_DATA_W-1:0]  m_tdata,   // out_red[7:0] out_green[15:8] out_blue[23:16]
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output      logic [31:0]          prdata,
  output      logic                 pready
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                  state;
  logic [DIM_W-1:0]        tex_width;
  logic [DIM_W-1:0]        tex_height;
  logic [COORD_W-1:0]      u_q;
  logic [COORD_W-1:0]      v_q;
  logic [DIM_W-1:0]        x0, x1, y0, y1;
  logic [FRAC_W-1:0]       fx, fy;
  logic [TEX_AW-1:0]       base0, base1;
  logic [TEXEL_W-1:0]      tex [4];   // 0:(x0,y0) 1:(x1,y0) 2:(x0,y1) 3:(x1,y1)
  logic [23:0]             r0;        // top row blend, Q8.16
  logic [7:0]              res [3];   // red, green, blue
  logic [2:0]              cnt;       // texel read slot
  logic [1:0]              ch;        // channel under blend
  logic [1:0]              ph;        // multiply phase within a channel
  logic signed [43:0]      prod;      // shared multiplier output register

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Clamped neighbour pair from q = floor(c*dim) = floor(position) + 1
  function automatic logic [2*DIM_W-1:0] locate_pair(input logic [9:0] q,
                                                     input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] maxi;
    logic [9:0]       lo;
    logic [9:0]       hi;
    maxi = (dim == '0) ? '0 : dim - 1'b1;
    lo   = (q == '0) ? '0 : q - 10'd1;
    hi   = q;
    if (lo > {1'b0, maxi}) lo = {1'b0, maxi};
    if (hi > {1'b0, maxi}) hi = {1'b0, maxi};
    return {lo[DIM_W-1:0], hi[DIM_W-1:0]};
  endfunction

  function automatic logic [7:0] chan(input logic [TEXEL_W-1:0] t, input logic [1:0] c);
    logic [7:0] v;
    unique case (c)
      2'd0:    v = t[23:16];
      2'd1:    v = t[15:8];
      default: v = t[7:0];
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Handshakes and configuration
  // --------------------------------------------------------------------------
  logic s_beat;
  logic cfg_wr;
  logic out_load;   // finished sample moves into the output register

  assign s_tready = (state == ST_IDLE);
  assign s_beat   = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_TEX_HEIGHT) ? {23'd0, tex_height} : {23'd0, tex_width};

  // --------------------------------------------------------------------------
  // Shared multiplier operand select
  // --------------------------------------------------------------------------
  logic signed [25:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [8:0]  col_diff;
  logic [7:0]         row_left;
  logic signed [25:0] row_sum;
  logic signed [43:0] fin_sum;

  // right minus left texel of the current row, row 0 in phase 0, row 1 otherwise
  assign col_diff = (ph == 2'd0)
                  ? $signed({1'b0, chan(tex[1], ch)}) - $signed({1'b0, chan(tex[0], ch)})
                  : $signed({1'b0, chan(tex[3], ch)}) - $signed({1'b0, chan(tex[2], ch)});
  // left texel * 65536 + (right - left) * fx, using the product from last cycle
  assign row_left = (ph == 2'd1) ? chan(tex[0], ch) : chan(tex[2], ch);
  assign row_sum  = $signed({2'b00, row_left, 16'd0}) + prod[25:0];
  // r0 * 65536 + (r1 - r0) * fy + rounding half
  assign fin_sum  = $signed({4'd0, r0, 16'd0}) + prod + $signed(44'h0_8000_0000);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MULX: begin
        mul_a = $signed({9'd0, u_q});
        mul_b = $signed({9'd0, tex_width});
      end
      ST_MULY: begin
        mul_a = $signed({9'd0, v_q});
        mul_b = $signed({9'd0, tex_height});
      end
      ST_BASE0: begin
        mul_a = $signed({17'd0, y0});
        mul_b = $signed({9'd0, tex_width});
      end
      ST_BASE1: begin
        mul_a = $signed({17'd0, y1});
        mul_b = $signed({9'd0, tex_width});
      end
      ST_BLEND: begin
        if (ph == 2'd2) begin
          mul_a = row_sum - $signed({2'b00, r0});
          mul_b = $signed({2'b00, fy});
        end else begin
          mul_a = 26'(col_diff);
          mul_b = $signed({2'b00, fx});
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // Texel store, single port, registered read
  // --------------------------------------------------------------------------
  logic [TEXEL_W-1:0] mem [MAX_TEXELS];
  logic [TEXEL_W-1:0] mem_rdata;
  logic [TEX_AW-1:0]  mem_addr;
  logic [TEX_AW-1:0]  rd_addr;
  logic               mem_we;
  logic [15:0]        wr_index;

  assign wr_index = s_tdata[IDX_LSB +: 16];
  assign mem_we   = s_beat && (s_tuser == KIND_WRITE) && (32'(wr_index) < MAX_TEXELS);
  assign rd_addr  = (cnt[1] ? base1 : base0) + TEX_AW'(cnt[0] ? x1 : x0);
  assign mem_addr = (state == ST_READ) ? rd_addr : wr_index[TEX_AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= {s_tdata[RED_LSB +: 8], s_tdata[GREEN_LSB +: 8], s_tdata[BLUE_LSB +: 8]};
    end
    mem_rdata <= mem[mem_addr];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      m_tvalid   <= 1'b0;
      tex_width  <= '0;
      tex_height <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_TEX_HEIGHT) tex_height <= pwdata[DIM_W-1:0];
        else                            tex_width  <= pwdata[DIM_W-1:0];
      end
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_beat && (s_tuser == KIND_SAMPLE)) begin
            u_q <= s_tdata[U_LSB +: COORD_W];
            v_q <= s_tdata[V_LSB +: COORD_W];
            if (tex_width == '0) begin
              res[0] <= WHITE;
              res[1] <= WHITE;
              res[2] <= WHITE;
              state  <= ST_DONE;
            end else begin
              state <= ST_MULX;
            end
          end
        end
        ST_MULX: state <= ST_MULY;
        ST_MULY: begin
          {x0, x1} <= locate_pair(prod[25:16], tex_width);
          fx       <= prod[15:0];
          state    <= ST_LOCY;
        end
        ST_LOCY: begin
          {y0, y1} <= locate_pair(prod[25:16], tex_height);
          fy       <= prod[15:0];
          state    <= ST_BASE0;
        end
        ST_BASE0: state <= ST_BASE1;
        ST_BASE1: begin
          base0 <= prod[TEX_AW-1:0];
          cnt   <= '0;
          state <= ST_READ;
        end
        ST_READ: begin
          // read issued in slot n lands in slot n+1
          if (cnt == 3'd0) base1 <= prod[TEX_AW-1:0];
          else             tex[cnt[1:0] - 2'd1] <= mem_rdata;
          if (cnt == 3'd4) begin
            ch    <= '0;
            ph    <= '0;
            state <= ST_BLEND;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_BLEND: begin
          // phase 0 also retires the previous channel
          if (ph == 2'd0 && ch != 2'd0) res[ch - 2'd1] <= fin_sum[39:32];
          if (ph == 2'd1) r0 <= row_sum[23:0];
          if (ch == 2'd3) begin
            state <= ST_DONE;
          end else if (ph == 2'd2) begin
            ph <= '0;
            ch <= ch + 2'd1;
          end else begin
            ph <= ph + 2'd1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            m_tdata <= {res[2], res[1], res[0]};
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sample_start: assert property (@(posedge clk) disable iff (rst)
    (s_beat && s_tuser == KIND_SAMPLE && tex_width != '0) |=> state == ST_MULX)
    else $error("sample with a texture did not start the multiply sequence");

  a_read_slots: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> cnt <= 3'd4)
    else $error("texel read slot out of range");

  a_blend_phase: assert property (@(posedge clk) disable iff (rst)
    state == ST_BLEND |-> (ph <= 2'd2) && (ch != 2'd3 || ph == 2'd0))
    else $error("blend phase or channel out of range");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && state == ST_IDLE))
    else $error("finished sample not moved to the output register");

endmodule

`default_nettype wire

// ===== tb/bilinear_texture_sampler_tb.sv =====
// ============================================================================
// bilinear_texture_sampler_tb : self-checking bench for the texture sampler
// Loads texels, programs the texture size over APB and streams write and
// sample beats. A behavioral mirror of the store and of the bilinear blend
// predicts each result not pinned by a directed row; every result beat is
// checked field by field in order. Pacing runs through phases of no idling,
// sender gaps, receiver stalls and both at once.
// ============================================================================
`default_nettype none

module bilinear_texture_sampler_tb;
  import bts_pkg::*;

  // Result color in m_tdata layout: red lowest
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Directed rows. Config rows carry the width in u and the height in v.
  typedef enum logic [1:0] {ROW_CONFIG, ROW_WRITE, ROW_SAMPLE} row_op_t;

  typedef struct packed {
    row_op_t              op;
    logic [15:0]          idx;
    rgb_t                 color;
    logic [COORD_W-1:0]   u;
    logic [COORD_W-1:0]   v;
    logic                 pinned;   // want holds the typed-in result
    rgb_t                 want;
  } row_t;

  typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  localparam logic [PADDR_W-1:0] ADDR_TEX_WIDTH  = {REG_TEX_WIDTH, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_TEX_HEIGHT = {REG_TEX_HEIGHT, 2'b00};

  localparam int SETTLE_CYCLES   = 32;
  localparam int QUIET_LIMIT     = 3000;   // cycles with no beat moving
  localparam int ITEMS_PER_PHASE = 110;
  localparam int RANDOM_PHASES   = 12;
  localparam int WRITE_PCT       = 35;
  localparam longint ONE_Q16     = 65536;

  // Fixed texture sizes; later phases pick the size at random
  localparam int PHASE_W [8] = '{256, 17, 1, 256, 0, 1, 3, 2};
  localparam int PHASE_H [8] = '{256, 5, 1, 0, 37, 256, 256, 2};

  // Colors below are {blue, green, red}
  localparam row_t DIRECTED_ROWS [22] = '{
    // no texture: white whatever the coordinates
    '{ROW_CONFIG, 16'd0,     24'h000000, 17'd0,      17'd0,      1'b0, 24'h000000},
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd0,      17'd0,      1'b1, 24'hFFFFFF},
    '{ROW_SAMPLE, 16'hFFFF,  24'hFFFFFF, 17'h1FFFF,  17'h1FFFF,  1'b1, 24'hFFFFFF},
    // 2x2 texture: red, green / blue, white, plus the last store entry
    '{ROW_CONFIG, 16'd0,     24'h000000, 17'd2,      17'd2,      1'b0, 24'h000000},
    '{ROW_WRITE,  16'd0,     24'h0000FF, 17'd0,      17'd0,      1'b0, 24'h000000},
    '{ROW_WRITE,  16'd1,     24'h00FF00, 17'd0,      17'd0,      1'b0, 24'h000000},
    '{ROW_WRITE,  16'd2,     24'hFF0000, 17'd0,      17'd0,      1'b0, 24'h000000},
    '{ROW_WRITE,  16'd3,     24'hFFFFFF, 17'd0,      17'd0,      1'b0, 24'h000000},
    '{ROW_WRITE,  16'hFFFF,  24'hFF55AA, 17'h1FFFF,  17'h1FFFF,  1'b0, 24'h000000},
    // origin and tiny coordinates sit left of texel 0 and clamp to it
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd0,      17'd0,      1'b1, 24'h0000FF},
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd1,      17'd1,      1'b1, 24'h0000FF},
    // 1.0 and the field maximum both clamp to the last texel
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd65536,  17'd65536,  1'b1, 24'hFFFFFF},
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'h1FFFF,  17'h1FFFF,  1'b1, 24'hFFFFFF},
    // half weights on all four: rounding ties go up; then uneven weights
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd49152,  17'd49152,  1'b0, 24'h000000},
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd40000,  17'd20000,  1'b0, 24'h000000},
    // zero height: rows clamp to row 0
    '{ROW_CONFIG, 16'd0,     24'h000000, 17'd2,      17'd0,      1'b0, 24'h000000},
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd49152,  17'd65536,  1'b0, 24'h000000},
    // largest texture, far corner and origin
    '{ROW_CONFIG, 16'd0,     24'h000000, 17'd256,    17'd256,    1'b0, 24'h000000},
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd65536,  17'd65536,  1'b1, 24'hFF55AA},
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd0,      17'd0,      1'b1, 24'h0000FF},
    // single texel
    '{ROW_CONFIG, 16'd0,     24'h000000, 17'd1,      17'd1,      1'b0, 24'h000000},
    '{ROW_SAMPLE, 16'd0,     24'h000000, 17'd100000, 17'd3,      1'b1, 24'h0000FF}
  };

  // --------------------------------------------------------------------------
  // DUT signals, those the bench drives set from time zero
  // --------------------------------------------------------------------------
  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;   // see pack_beat for the field layout
  logic                s_tuser  = 1'b0; // kind[0]
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;         // out_red[7:0] out_green[15:8] out_blue[23:16]
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [PADDR_W-1:0]  paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;

  bilinear_texture_sampler DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Mirror state: texture store, size registers, pending results
  // --------------------------------------------------------------------------
  rgb_t        texel_mirror [MAX_TEXELS];
  bit          texel_loaded [MAX_TEXELS];   // entry written since reset
  logic [8:0]  tex_w = '0;
  logic [8:0]  tex_h = '0;
  rgb_t        expected_colors [$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 0;
  int          stall_pct      = 0;
  int          quiet_cycles   = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Neighbor pair and fraction along one axis: p = c*dim - 1.0 in Q.16.
  // Negative p means floor -1, so both indices clamp to 0.
  function automatic void axis_span(input longint c, input longint dim,
                                    output longint lo, output longint hi,
                                    output longint frac);
    longint p, ip, maxi;
    p    = c * dim - ONE_Q16;
    maxi = (dim == 0) ? 0 : dim - 1;
    if (p < 0) begin
      ip   = -1;
      frac = p + ONE_Q16;
    end else begin
      ip   = p >>> 16;
      frac = p & 64'hFFFF;
    end
    lo = (ip < 0) ? 0 : ((ip > maxi) ? maxi : ip);
    hi = (ip + 1 > maxi) ? maxi : ip + 1;
  endfunction

  // Row address wraps on the store size
  function automatic int texel_addr(input longint x, input longint y);
    return int'((y * longint'(tex_w) + x) % MAX_TEXELS);
  endfunction

  function automatic rgb_t texel_at(input longint x, input longint y);
    return texel_mirror[texel_addr(x, y)];
  endfunction

  // Rows blended in Q.16, columns in Q.32, round half up
  function automatic logic [7:0] blend_channel(input logic [7:0] c00, c10, c01, c11,
                                               input longint fx, fy);
    longint r0, r1, s;
    r0 = longint'(c00) * (ONE_Q16 - fx) + longint'(c10) * fx;
    r1 = longint'(c01) * (ONE_Q16 - fx) + longint'(c11) * fx;
    s  = r0 * (ONE_Q16 - fy) + r1 * fy;
    return 8'((s + 64'h8000_0000) >> 32);
  endfunction

  function automatic rgb_t bilinear_color(input logic [COORD_W-1:0] u, v);
    longint x0, x1, y0, y1, fx, fy;
    rgb_t   t00, t10, t01, t11, res;
    if (tex_w == 0) return rgb_t'(24'hFFFFFF);   // zero width: white
    axis_span(longint'(u), longint'(tex_w), x0, x1, fx);
    axis_span(longint'(v), longint'(tex_h), y0, y1, fy);
    t00 = texel_at(x0, y0);
    t10 = texel_at(x1, y0);
    t01 = texel_at(x0, y1);
    t11 = texel_at(x1, y1);
    res.red   = blend_channel(t00.red,   t10.red,   t01.red,   t11.red,   fx, fy);
    res.green = blend_channel(t00.green, t10.green, t01.green, t11.green, fx, fy);
    res.blue  = blend_channel(t00.blue,  t10.blue,  t01.blue,  t11.blue,  fx, fy);
    return res;
  endfunction

  // s_tdata: texel_index, red, green, blue, coord_u, coord_v, zero pad
  function automatic logic [S_DATA_W-1:0] pack_beat(input logic [15:0] idx,
                                                    input rgb_t color,
                                                    input logic [COORD_W-1:0] u, v);
    logic [S_DATA_W-1:0] d;
    d = '0;
    d[IDX_LSB +: 16]      = idx;
    d[RED_LSB +: 8]       = color.red;
    d[GREEN_LSB +: 8]     = color.green;
    d[BLUE_LSB +: 8]      = color.blue;
    d[U_LSB +: COORD_W]   = u;
    d[V_LSB +: COORD_W]   = v;
    return d;
  endfunction

  // Coordinates weighted toward the corners and the clamp region
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return COORD_W'(ONE_Q16);
      2:       return COORD_W'($urandom);           // past 1.0 too
      3:       return COORD_W'($urandom_range(1023));
      default: return COORD_W'($urandom_range(65536));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Called right after a rising edge; returns at the edge where
  // the beat is taken, with s_tvalid still high so the next beat can follow.
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic kind, input logic [15:0] idx, input rgb_t color,
                           input logic [COORD_W-1:0] u, v,
                           input logic use_want, input rgb_t want);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= pack_beat(idx, color, u, v);
    do @(posedge clk); while (!s_tready);
    // beat taken at this edge: update the mirror
    if (kind == KIND_WRITE) begin
      texel_mirror[idx] = color;
      texel_loaded[idx] = 1'b1;
    end else begin
      expected_colors.push_back(use_want ? want : bilinear_color(u, v));
    end
  endtask

  // Write every texel a sample at (u, v) reaches that was never loaded
  task automatic load_footprint(input logic [COORD_W-1:0] u, v, inout int sent);
    longint x0, x1, y0, y1, fx, fy;
    int     addr [4];
    if (tex_w == 0) return;
    axis_span(longint'(u), longint'(tex_w), x0, x1, fx);
    axis_span(longint'(v), longint'(tex_h), y0, y1, fy);
    addr = '{texel_addr(x0, y0), texel_addr(x1, y0), texel_addr(x0, y1),
             texel_addr(x1, y1)};
    foreach (addr[k]) begin
      if (!texel_loaded[addr[k]]) begin
        push_beat(KIND_WRITE, 16'(addr[k]), rgb_t'(24'($urandom)), u, v, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Block idle: no results pending, and writes had time to land
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB transfers: setup, access, then idle
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [8:0] w, input logic [8:0] h);
    logic [31:0] rd;
    apb_write(ADDR_TEX_WIDTH, 32'(w));
    apb_write(ADDR_TEX_HEIGHT, 32'(h));
    tex_w = w;
    tex_h = h;
    apb_read(ADDR_TEX_WIDTH, rd);
    if (rd[DIM_W-1:0] != w) report_mismatch("tex_width readback", rd, 32'(w));
    apb_read(ADDR_TEX_HEIGHT, rd);
    if (rd[DIM_W-1:0] != h) report_mismatch("tex_height readback", rd, 32'(h));
  endtask

  task automatic set_pacing(input pace_t pace);
    case (pace)
      PACE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      PACE_SENDER:   begin send_idle_pct = 86; stall_pct = 0;  end
      PACE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 86; end
      PACE_BOTH:     begin send_idle_pct = 36; stall_pct = 36; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, in-order compare of every result beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rgb_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = rgb_t'(m_tdata);
        if (expected_colors.size() == 0) begin
          report_mismatch("result beat with none pending", 32'(m_tdata), 0);
        end else begin
          want = expected_colors.pop_front();
          if (got.red != want.red)
            report_mismatch("out_red", 32'(got.red), 32'(want.red));
          if (got.green != want.green)
            report_mismatch("out_green", 32'(got.green), 32'(want.green));
          if (got.blue != want.blue)
            report_mismatch("out_blue", 32'(got.blue), 32'(want.blue));
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: too long with no beat moving on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    row_t               row;
    int                 w, h;
    int                 sent;
    logic               kind;
    logic [15:0]        idx;
    logic [COORD_W-1:0] cu, cv;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, no idling
    set_pacing(PACE_NONE);
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      case (row.op)
        ROW_CONFIG: begin
          quiesce();
          configure(9'(row.u), 9'(row.v));
        end
        ROW_WRITE:  push_beat(KIND_WRITE, row.idx, row.color, row.u, row.v, 1'b0, row.want);
        ROW_SAMPLE: push_beat(KIND_SAMPLE, row.idx, row.color, row.u, row.v,
                              row.pinned, row.want);
        default: ;
      endcase
    end

    // Random phases: size changes only while idle, pacing cycles every phase.
    // Texels a sample reaches are written first; those writes count as items.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < $size(PHASE_W)) begin
        w = PHASE_W[ph];
        h = PHASE_H[ph];
      end else begin
        w = $urandom_range(256, 1);
        h = $urandom_range(256, 0);
      end
      quiesce();
      configure(9'(w), 9'(h));
      set_pacing(pace_t'(ph % 4));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        kind = ($urandom_range(99) < WRITE_PCT) ? KIND_WRITE : KIND_SAMPLE;
        idx  = 16'($urandom);
        cu   = pick_coord();
        cv   = pick_coord();
        if (kind == KIND_SAMPLE) load_footprint(cu, cv, sent);
        // unused fields of each beat carry noise
        push_beat(kind, idx, rgb_t'(24'($urandom)), cu, cv, 1'b0, '0);
        sent++;
      end
    end

    // Drain, then let the last writes settle
    quiesce();
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
